// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i with reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_PROP(lbl, !(cond), msg)

`endif

// File: hw/rtl/est_pkg.sv
// ----------------------------------------------------------------------------
// est_pkg
// Types, constants and the code letter lookup of the escape sequence tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package est_pkg;

  localparam int ArgBufferBytesDefault = 128;
  localparam int ResultFifoDepth = 4;

  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChRbrace = 8'h7D;
  localparam logic [7:0] ChBslash = 8'h5C;

  typedef enum logic [1:0] {
    MODE_TEXT   = 2'd0,
    MODE_BSLASH = 2'd1,
    MODE_ESC    = 2'd2,
    MODE_ARG    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KIND_TEXT    = 3'd0,
    KIND_ESC     = 3'd1,
    KIND_ARGBYTE = 3'd2,
    KIND_ARGEND  = 3'd3,
    KIND_ABANDON = 3'd4,
    KIND_END     = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  char_value;
    logic [4:0]  escape_id;
    logic        last;
  } result_t;

  // Position (1..19) of a code letter in the escape table, zero if unknown.
  function automatic logic [4:0] lookup_code(input logic [7:0] b);
    logic [4:0] id;
    case (b)
      8'h73:   id = 5'd1;   // s
      8'h6E:   id = 5'd2;   // n
      8'h72:   id = 5'd3;   // r
      8'h76:   id = 5'd4;   // v
      8'h6D:   id = 5'd5;   // m
      8'h6F:   id = 5'd6;   // o
      8'h4F:   id = 5'd7;   // O
      8'h64:   id = 5'd8;   // d
      8'h74:   id = 5'd9;   // t
      8'h6C:   id = 5'd10;  // l
      8'h62:   id = 5'd11;  // b
      8'h53:   id = 5'd12;  // S
      8'h75:   id = 5'd13;  // u
      8'h55:   id = 5'd14;  // U
      8'h65:   id = 5'd15;  // e
      8'h34:   id = 5'd16;  // 4
      8'h36:   id = 5'd17;  // 6
      8'h61:   id = 5'd18;  // a
      8'h41:   id = 5'd19;  // A
      default: id = 5'd0;
    endcase
    return id;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/escape_sequence_tokenizer_unit.sv
// The results of an accepted word are written into the result queue, whose head drives the output.
// Throughput: one input word per cycle while words give at most one result each and the
// output keeps up. A word that gives two results queues both for the single output port
// draining a four-entry result queue; input is taken while two queue slots are free.
// Reset: asynchronous, clears the parse mode, the argument count and the result queue.
// ----------------------------------------------------------------------------
// escape_sequence_tokenizer_unit
// Splits a byte stream into text, escape, argument and end tokens, one byte per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module escape_sequence_tokenizer_unit #(
  parameter int ARG_BUFFER_BYTES = est_pkg::ArgBufferBytesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  wire logic [0:0]  s_axis_tuser,   // end_mark[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // char_value[7:0], escape_id[12:8], zero[15:13]
  output logic [2:0]       m_axis_tuser,   // kind[2:0]
  output logic             m_axis_tlast
);

  localparam int CntW = (ARG_BUFFER_BYTES > 2) ? $clog2(ARG_BUFFER_BYTES) : 1;
  localparam logic [CntW-1:0] CntMax = CntW'(ARG_BUFFER_BYTES - 1);
  localparam int Depth = est_pkg::ResultFifoDepth;
  localparam int PtrW = $clog2(Depth);
  localparam int FillW = PtrW + 1;

  est_pkg::mode_e   mode_q, mode_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  est_pkg::result_t fifo_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0] fill_q;

  est_pkg::result_t res0, res1;
  logic [1:0]       n_res;
  logic [7:0]       b;
  logic             end_mark;
  logic [4:0]       id;
  logic             in_acc, out_acc;

  assign b        = s_axis_tdata;
  assign end_mark = s_axis_tuser[0];
  assign id       = est_pkg::lookup_code(b);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_acc  = m_axis_tvalid && m_axis_tready;

  assign s_axis_tready = (fill_q <= FillW'(Depth - 2));

  always_comb begin
    res0 = '{kind: est_pkg::KIND_TEXT, char_value: 8'd0, escape_id: 5'd0, last: 1'b0};
    res1 = '{kind: est_pkg::KIND_TEXT, char_value: 8'd0, escape_id: 5'd0, last: 1'b1};
    n_res  = 2'd0;
    mode_d = mode_q;
    cnt_d  = cnt_q;
    if (end_mark) begin
      if (mode_q == est_pkg::MODE_ARG) begin
        res0.kind = est_pkg::KIND_ABANDON;
        res1.kind = est_pkg::KIND_END;
        n_res     = 2'd2;
      end else begin
        res0.kind = est_pkg::KIND_END;
        n_res     = 2'd1;
      end
      mode_d = est_pkg::MODE_TEXT;
      cnt_d  = '0;
    end else begin
      case (mode_q)
        est_pkg::MODE_BSLASH: begin
          if (id == 5'd0) begin
            res0.char_value = est_pkg::ChBslash;
            res1.char_value = b;
            n_res  = 2'd2;
            mode_d = est_pkg::MODE_TEXT;
          end else begin
            res0.kind      = est_pkg::KIND_ESC;
            res0.escape_id = id;
            n_res  = 2'd1;
            mode_d = est_pkg::MODE_ESC;
          end
        end
        est_pkg::MODE_ARG: begin
          if (b == est_pkg::ChRbrace) begin
            res0.kind = est_pkg::KIND_ARGEND;
            n_res  = 2'd1;
            mode_d = est_pkg::MODE_TEXT;
            cnt_d  = '0;
          end else if (cnt_q < CntMax) begin
            res0.kind       = est_pkg::KIND_ARGBYTE;
            res0.char_value = b;
            n_res = 2'd1;
            cnt_d = cnt_q + CntW'(1);
          end
        end
        default: begin
          if (mode_q == est_pkg::MODE_ESC && b == est_pkg::ChLbrace) begin
            mode_d = est_pkg::MODE_ARG;
            cnt_d  = '0;
          end else if (b == est_pkg::ChBslash) begin
            mode_d = est_pkg::MODE_BSLASH;
          end else begin
            res0.char_value = b;
            n_res  = 2'd1;
            mode_d = est_pkg::MODE_TEXT;
          end
        end
      endcase
    end
    res0.last = (n_res == 2'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= est_pkg::MODE_TEXT;
      cnt_q  <= '0;
    end else if (in_acc) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  logic [1:0] n_push;
  assign n_push = in_acc ? n_res : 2'd0;

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (n_push == 2'd2) begin
      fifo_q[wr_ptr_q + PtrW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(n_push);
      rd_ptr_q <= rd_ptr_q + PtrW'(out_acc);
      fill_q   <= fill_q + FillW'(n_push) - FillW'(out_acc);
    end
  end

  assign m_axis_tvalid = (fill_q != '0);
  assign m_axis_tdata  = {3'b000, fifo_q[rd_ptr_q].escape_id, fifo_q[rd_ptr_q].char_value};
  assign m_axis_tuser  = fifo_q[rd_ptr_q].kind;
  assign m_axis_tlast  = fifo_q[rd_ptr_q].last;

  `ASSERT_NEVER(a_fill_bound, fill_q > FillW'(Depth), "result queue overfilled")
  `ASSERT_NEVER(a_cnt_bound, cnt_q > CntMax, "argument count beyond limit")
  `ASSERT_PROP(a_end_resets, in_acc && end_mark |=> mode_q == est_pkg::MODE_TEXT && cnt_q == '0, "end of stream did not return to text mode")
  `ASSERT_PROP(a_push_shows, in_acc && n_res != 2'd0 |=> m_axis_tvalid, "pushed result not presented")

endmodule

`default_nettype wire

// File: tb/sv/est_token_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// est_token_checker
// Watches both streams of the escape sequence tokenizer. It predicts the tokens
// that each accepted byte word should give and compares every output word
// with the oldest predicted token, field by field.
// ----------------------------------------------------------------------------
module est_token_checker
  import est_pkg::*;
#(
  parameter int ArgBytes = est_pkg::ArgBufferBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_data_i,
  input  logic [0:0]  in_user_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] out_data_i,
  input  logic [2:0]  out_user_i,
  input  logic        out_last_i,
  output int          mismatches_o,
  output int          pending_o,
  output int          tokens_o,
  output int          escapes_o,
  output int          dropped_o
);

  localparam string CodeOrder = "snrvmoOdtlbSuUe46aA";

  mode_e   tok_mode;
  int      kept_bytes;
  result_t expected_tokens[$];

  function automatic logic [4:0] code_position(input logic [7:0] b);
    logic [4:0] pos;
    pos = 5'd0;
    for (int i = 0; i < CodeOrder.len(); i++) begin
      if (pos == 5'd0 && CodeOrder[i] == b) begin
        pos = 5'(i + 1);
      end
    end
    return pos;
  endfunction

  function automatic result_t make_token(input kind_e k, input logic [7:0] ch,
                                         input logic [4:0] id);
    result_t t;
    t.kind       = k;
    t.char_value = ch;
    t.escape_id  = id;
    t.last       = 1'b0;
    return t;
  endfunction

  function automatic void predict_tokens(input logic [7:0] b, input logic end_mark);
    result_t    tok[2];
    int         n;
    logic [4:0] id;
    n = 0;
    if (end_mark) begin
      if (tok_mode == MODE_ARG) begin
        tok[n] = make_token(KIND_ABANDON, 8'd0, 5'd0);
        n = n + 1;
      end
      tok[n]     = make_token(KIND_END, 8'd0, 5'd0);
      n          = n + 1;
      tok_mode   = MODE_TEXT;
      kept_bytes = 0;
    end else begin
      case (tok_mode)
        MODE_BSLASH: begin
          id = code_position(b);
          if (id == 5'd0) begin
            tok[0]   = make_token(KIND_TEXT, ChBslash, 5'd0);
            tok[1]   = make_token(KIND_TEXT, b, 5'd0);
            n        = 2;
            tok_mode = MODE_TEXT;
          end else begin
            tok[0]   = make_token(KIND_ESC, 8'd0, id);
            n        = 1;
            tok_mode = MODE_ESC;
          end
        end
        MODE_ARG: begin
          if (b == ChRbrace) begin
            tok[0]     = make_token(KIND_ARGEND, 8'd0, 5'd0);
            n          = 1;
            tok_mode   = MODE_TEXT;
            kept_bytes = 0;
          end else if (kept_bytes < ArgBytes - 1) begin
            tok[0]     = make_token(KIND_ARGBYTE, b, 5'd0);
            n          = 1;
            kept_bytes = kept_bytes + 1;
          end else begin
            dropped_o = dropped_o + 1;
          end
        end
        default: begin
          if (tok_mode == MODE_ESC && b == ChLbrace) begin
            tok_mode   = MODE_ARG;
            kept_bytes = 0;
          end else if (b == ChBslash) begin
            tok_mode = MODE_BSLASH;
          end else begin
            tok[0]   = make_token(KIND_TEXT, b, 5'd0);
            n        = 1;
            tok_mode = MODE_TEXT;
          end
        end
      endcase
    end
    if (n > 0) begin
      tok[n - 1].last = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      expected_tokens.push_back(tok[i]);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns, token %0d: %s", $time, tokens_o, msg);
    mismatches_o = mismatches_o + 1;
  endtask

  task automatic check_token();
    result_t exp_tok;
    if (expected_tokens.size() == 0) begin
      report_mismatch($sformatf("unexpected word, kind %0d data %h", out_user_i,
                                out_data_i));
    end else begin
      exp_tok = expected_tokens.pop_front();
      if (out_user_i != exp_tok.kind) begin
        report_mismatch($sformatf("kind %0d, expected %0d", out_user_i, exp_tok.kind));
      end
      if (out_data_i[7:0] != exp_tok.char_value) begin
        report_mismatch($sformatf("char_value %h, expected %h", out_data_i[7:0],
                                  exp_tok.char_value));
      end
      if (out_data_i[12:8] != exp_tok.escape_id) begin
        report_mismatch($sformatf("escape_id %0d, expected %0d", out_data_i[12:8],
                                  exp_tok.escape_id));
      end
      if (out_data_i[15:13] != 3'd0) begin
        report_mismatch($sformatf("pad bits %b are not zero", out_data_i[15:13]));
      end
      if (out_last_i != exp_tok.last) begin
        report_mismatch($sformatf("last %b, expected %b", out_last_i, exp_tok.last));
      end
      if (exp_tok.kind == KIND_ESC) begin
        escapes_o = escapes_o + 1;
      end
    end
    tokens_o = tokens_o + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_mode   = MODE_TEXT;
      kept_bytes = 0;
      expected_tokens.delete();
      mismatches_o = 0;
      tokens_o     = 0;
      escapes_o    = 0;
      dropped_o    = 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        check_token();
      end
      if (in_valid_i && in_ready_i) begin
        predict_tokens(in_data_i, in_user_i[0]);
      end
      pending_o <= expected_tokens.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives byte words into the escape sequence tokenizer: a directed pass over
// its corner cases, then random text, escapes, arguments and stream ends,
// with random gaps on both streams. The checker judges every token.
// ----------------------------------------------------------------------------
module tb_top;
  import est_pkg::*;

  localparam int    ArgBytes   = est_pkg::ArgBufferBytesDefault;
  localparam int    CycleLimit = 300000;
  localparam int    RandWords  = 1800;
  localparam string CodeOrder  = "snrvmoOdtlbSuUe46aA";

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;
  logic [0:0]  s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int   mismatches;
  int   pending;
  int   tokens;
  int   escapes;
  int   dropped;
  int   words_sent = 0;
  int   cycle_count = 0;
  logic steady = 1'b0;

  escape_sequence_tokenizer_unit #(
    .ARG_BUFFER_BYTES(ArgBytes)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  est_token_checker #(
    .ArgBytes(ArgBytes)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .out_user_i  (m_axis_tuser),
    .out_last_i  (m_axis_tlast),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .tokens_o    (tokens),
    .escapes_o   (escapes),
    .dropped_o   (dropped)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 23);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Run stopped after %0d cycles with %0d tokens outstanding.", cycle_count,
               pending);
      $display("escape_sequence_tokenizer_unit regression: fail");
      $finish;
    end
  end

  task automatic send_word(input logic [7:0] b, input logic end_mark);
    while (!steady && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= end_mark;
    @(posedge clk_i);
    while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(b, 1'b0);
  endtask

  task automatic send_end();
    send_word(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic drain_tokens();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic send_argument(input int len);
    logic [7:0] b;
    send_byte(ChLbrace);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      if (b == ChRbrace) begin
        b = 8'h7C;
      end
      send_byte(b);
    end
  endtask

  task automatic send_random_run();
    int pick;
    int sel;
    int len;
    pick = $urandom_range(99);
    if (pick < 40) begin
      send_byte(8'($urandom_range(255)));
    end else if (pick < 80) begin
      send_byte(ChBslash);
      send_byte(8'(CodeOrder[$urandom_range(18)]));
      sel = $urandom_range(99);
      if (sel < 65) begin
        len = ($urandom_range(99) < 4) ? $urandom_range(ArgBytes - 8, ArgBytes + 12)
                                       : $urandom_range(0, 8);
        send_argument(len);
        sel = $urandom_range(99);
        if (sel < 8) begin
          send_end();
        end else if (sel >= 13) begin
          send_byte(ChRbrace);
        end
      end
    end else if (pick < 92) begin
      send_byte(ChBslash);
      send_byte(8'($urandom_range(255)));
    end else if (pick < 96) begin
      send_byte(ChBslash);
      if ($urandom_range(1) == 1) begin
        send_end();
      end
    end else begin
      send_end();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corner cases.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ChRbrace);
    send_byte(ChBslash);
    send_byte(8'h73);
    send_byte(ChLbrace);
    send_byte(8'h00);
    send_byte(ChBslash);
    send_byte(ChRbrace);
    send_byte(ChBslash);
    send_byte(ChBslash);
    send_byte(ChBslash);
    send_byte(8'h41);
    send_byte(8'h7A);
    send_byte(ChBslash);
    send_byte(8'h00);
    send_byte(ChBslash);
    send_byte(8'h6E);
    send_byte(ChBslash);
    send_byte(8'h74);
    send_byte(ChLbrace);
    send_byte(8'h80);
    send_end();
    send_byte(ChBslash);
    send_end();
    send_byte(ChBslash);
    send_byte(8'h61);
    send_end();
    send_end();
    drain_tokens();

    // Every code letter once, with an argument that overruns the length cap.
    for (int i = 0; i < CodeOrder.len(); i++) begin
      send_byte(ChBslash);
      send_byte(8'(CodeOrder[i]));
    end
    send_argument(ArgBytes + 4);
    send_byte(ChRbrace);

    while (words_sent < RandWords) begin
      steady = (words_sent >= 700 && words_sent < 1100);
      send_random_run();
      if (words_sent >= 1200 && words_sent < 1215) begin
        drain_tokens();
      end
    end
    steady = 1'b0;
    send_end();

    drain_tokens();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d words; checked %0d tokens, %0d of them escapes.", words_sent,
             tokens, escapes);
    $display("Argument bytes dropped past the length cap: %0d.", dropped);
    if (mismatches == 0) begin
      $display("escape_sequence_tokenizer_unit regression: pass");
    end else begin
      $display("escape_sequence_tokenizer_unit regression: fail");
    end
    $finish;
  end

endmodule
